### design/codel_drop_decider_macros.svh
// Assertion macros for the drop decider
`ifndef CODEL_DROP_DECIDER_MACROS_SVH
`define CODEL_DROP_DECIDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CODEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CODEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/codel_pkg.sv
package codel_pkg;

  localparam int IN_TIME_BITS   = 48;
  localparam int ADDR_BITS      = 32;
  localparam int LEN_BITS       = 16;
  localparam int REG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [REG_BITS-1:0] TARGET_DELAY_RESET  = 32'd5000000;
  localparam logic [REG_BITS-1:0] BASE_INTERVAL_RESET = 32'd100000000;
  localparam logic [REG_BITS-1:0] COUNT_MAX           = '1;

  localparam int DIV_STEPS  = 2 * REG_BITS;
  localparam int SQRT_STEPS = REG_BITS;
  localparam int ITER_BITS  = $clog2(DIV_STEPS);
  localparam int REM_BITS   = REG_BITS + 2;
  localparam int TRIAL_BITS = REG_BITS + 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TARGET_DELAY,
    CFG_BASE_INTERVAL
  } cfg_index_t;

  typedef struct packed {
    logic [IN_TIME_BITS-1:0] now_time;
    logic [IN_TIME_BITS-1:0] arrival_time;
    logic [ADDR_BITS-1:0]    buffer_address;
    logic [LEN_BITS-1:0]     frame_length;
  } in_item_t;

  typedef struct packed {
    logic                 decision;
    logic [ADDR_BITS-1:0] out_address;
    logic [LEN_BITS-1:0]  out_length;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SOJ,
    S_DECIDE,
    S_STEP,
    S_DONE
  } decide_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_SQRT,
    U_DONE
  } step_state_t;

  typedef struct packed {
    logic                start;
    logic [REG_BITS-1:0] base;
    logic [REG_BITS-1:0] count;
  } step_req_t;

  typedef struct packed {
    logic                done;
    logic [REG_BITS-1:0] step;
  } step_rsp_t;

endpackage

### design/codel_stream_if.sv
interface codel_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/codel_step_unit.sv
module codel_step_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  codel_pkg::step_req_t req,
  output codel_pkg::step_rsp_t rsp
);
  import codel_pkg::*;

  step_state_t               state, state_next;
  logic [REG_BITS-1:0]       base;
  logic [REG_BITS-1:0]       divisor;
  logic [REG_BITS-1:0]       root;
  logic [2*REG_BITS-1:0]     work;
  logic [REM_BITS-1:0]       rem;
  logic [ITER_BITS-1:0]      iter;
  logic [TRIAL_BITS-1:0]     op_a, op_b;
  logic [TRIAL_BITS:0]       diff;
  logic                      ge;
  logic                      last;

  // shared trial subtract for division and square root
  always_comb begin
    op_a = TRIAL_BITS'({rem[REG_BITS-1:0], work[2*REG_BITS-1]});
    op_b = TRIAL_BITS'(divisor);
    if (state == U_SQRT) begin
      op_a = {rem[REM_BITS-2:0], work[2*REG_BITS-1 -: 2]};
      op_b = {1'b0, root, 2'b01};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[TRIAL_BITS];
  end

  assign last = (state == U_DIV) ? (iter == ITER_BITS'(DIV_STEPS - 1))
                                 : (iter == ITER_BITS'(SQRT_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: begin
        if (req.start) state_next = U_MUL;
      end
      U_MUL:  state_next = U_DIV;
      U_DIV: begin
        if (last) state_next = U_SQRT;
      end
      U_SQRT: begin
        if (last) state_next = U_DONE;
      end
      U_DONE: state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == U_DONE);
    rsp.step = root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (req.start) begin
          base    <= req.base;
          divisor <= req.count;
        end
      end
      U_MUL: begin
        work <= (2*REG_BITS)'(base) * (2*REG_BITS)'(base);
        rem  <= '0;
        iter <= '0;
      end
      U_DIV: begin
        work <= {work[2*REG_BITS-2:0], ge};
        if (last) begin
          rem  <= '0;
          iter <= '0;
          root <= '0;
        end else begin
          rem  <= ge ? diff[REM_BITS-1:0] : op_a[REM_BITS-1:0];
          iter <= ITER_BITS'(iter + 1'b1);
        end
      end
      U_SQRT: begin
        rem  <= ge ? diff[REM_BITS-1:0] : op_a[REM_BITS-1:0];
        work <= {work[2*REG_BITS-3:0], 2'b00};
        root <= {root[REG_BITS-2:0], ge};
        iter <= ITER_BITS'(iter + 1'b1);
      end
      default: begin
      end
    endcase
  end

endmodule

### design/codel_drop_decider.sv
// A packet goes from input transfer through S_SOJ and S_DECIDE to S_DONE; a
// dropped packet also waits in S_STEP for 64 divide steps and 32 square-root
// steps through one shared subtract unit, plus multiply and control. Packets
// are taken one at a time; the input is ready only in S_IDLE.
// Reset (rst, synchronous): configuration registers return to default
// values, the delay episode is cleared and no result is pending.
`include "codel_drop_decider_macros.svh"

module codel_drop_decider #(
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  codel_stream_if.sink                        in_ch,
  codel_stream_if.source                      out_ch,
  input  logic                                cfg_we,
  input  logic [codel_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [codel_pkg::REG_BITS-1:0]       cfg_data
);
  import codel_pkg::*;

  decide_state_t          state, state_next;
  logic [REG_BITS-1:0]    target_delay;
  logic [REG_BITS-1:0]    base_interval;
  logic                   episode_active;
  logic [TIME_BITS-1:0]   episode_start;
  logic [TIME_BITS-1:0]   drop_threshold;
  logic [REG_BITS-1:0]    drop_count;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   arr_t;
  logic [ADDR_BITS-1:0]   addr;
  logic [LEN_BITS-1:0]    len;
  logic [TIME_BITS-1:0]   sojourn;
  logic [TIME_BITS-1:0]   elapsed;
  logic                   decision_r;
  logic                   out_valid;
  out_item_t              out_item;

  logic                   in_fire;
  logic                   out_free;
  logic                   load_out;
  logic [TIME_BITS:0]     soj_diff;
  logic [TIME_BITS:0]     ela_diff;
  logic                   delayed;
  logic                   due;
  logic                   drop_go;
  logic [REG_BITS-1:0]    count_inc;
  logic [TIME_BITS:0]     thr_sum;
  step_req_t              step_req;
  step_rsp_t              step_rsp;

  codel_step_unit u_step (
    .clk (clk),
    .rst (rst),
    .req (step_req),
    .rsp (step_rsp)
  );

  always_comb begin
    soj_diff  = {1'b0, now_t} - {1'b0, arr_t};
    ela_diff  = {1'b0, now_t} - {1'b0, episode_start};
    delayed   = sojourn > TIME_BITS'(target_delay);
    due       = elapsed >= drop_threshold;
    drop_go   = delayed && episode_active && due;
    count_inc = (drop_count == COUNT_MAX) ? drop_count : drop_count + 1'b1;
    thr_sum   = {1'b0, drop_threshold} + (TIME_BITS+1)'(step_rsp.step);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_SOJ;
      end
      S_SOJ:    state_next = S_DECIDE;
      S_DECIDE: state_next = drop_go ? S_STEP : S_DONE;
      S_STEP: begin
        if (step_rsp.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = (state == S_IDLE);
    in_fire        = in_ch.valid && in_ch.ready;
    out_free       = !out_valid || out_ch.ready;
    load_out       = (state == S_DONE) && out_free;
    step_req.start = (state == S_DECIDE) && drop_go;
    step_req.base  = base_interval;
    step_req.count = count_inc;
    out_ch.valid   = out_valid;
    out_ch.payload = out_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay  <= TARGET_DELAY_RESET;
      base_interval <= BASE_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_DELAY:  target_delay  <= cfg_data;
        CFG_BASE_INTERVAL: base_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      episode_active <= 1'b0;
      episode_start  <= '0;
      drop_threshold <= TIME_BITS'(BASE_INTERVAL_RESET);
      drop_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_DECIDE) begin
        if (!delayed) begin
          if (episode_active) begin
            episode_active <= 1'b0;
            drop_threshold <= TIME_BITS'(base_interval);
            drop_count     <= '0;
          end
        end else if (!episode_active) begin
          episode_active <= 1'b1;
          episode_start  <= now_t;
        end else if (due) begin
          drop_count <= count_inc;
        end
      end
      // saturate on carry out of the threshold add
      if (state == S_STEP && step_rsp.done) begin
        drop_threshold <= thr_sum[TIME_BITS] ? '1 : thr_sum[TIME_BITS-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_t <= TIME_BITS'({{(64-IN_TIME_BITS){1'b0}}, in_ch.payload.now_time});
      arr_t <= TIME_BITS'({{(64-IN_TIME_BITS){1'b0}}, in_ch.payload.arrival_time});
      addr  <= in_ch.payload.buffer_address;
      len   <= in_ch.payload.frame_length;
    end
    if (state == S_SOJ) begin
      sojourn <= soj_diff[TIME_BITS] ? '0 : soj_diff[TIME_BITS-1:0];
      elapsed <= ela_diff[TIME_BITS] ? '0 : ela_diff[TIME_BITS-1:0];
    end
    if (state == S_DECIDE) begin
      decision_r <= drop_go;
    end
    if (load_out) begin
      out_item.decision    <= decision_r;
      out_item.out_address <= addr;
      out_item.out_length  <= len;
    end
  end

  `CODEL_ASSERT_NOW(a_drop_in_episode, (state == S_DONE) && decision_r, episode_active, "drop outside a delay episode")
  `CODEL_ASSERT_NOW(a_count_idle, !episode_active, drop_count == '0, "drop count nonzero with no episode")
  `CODEL_ASSERT_NOW(a_step_done_wait, step_rsp.done, state == S_STEP, "step result with no drop pending")
  `CODEL_ASSERT_NEXT(a_start_step, step_req.start, state == S_STEP, "step started without waiting")

endmodule
